// File: rtl/core/dssm_pkg.sv
package dssm_pkg;

    // Shared array geometry
    localparam int DEPTH   = 16;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int WORD_W  = 32;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;
    localparam int COUNT_FIELD_W = 5;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUSH_LEFT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_RIGHT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP_LEFT   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_POP_RIGHT  = 2'd3;

    // Status codes
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic load;     // capture the input transfer
        logic exec;     // perform the stack operation
        logic publish;  // move the result into the output register
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free; // output register can take a new result
    } dp_stat_t;

    // Count reported modulo 2**COUNT_FIELD_W
    function automatic logic [COUNT_FIELD_W-1:0] count_field(input logic [CNT_W-1:0] c);
        logic [CNT_W+COUNT_FIELD_W-1:0] ext;
        ext = {{COUNT_FIELD_W{1'b0}}, c};
        return ext[COUNT_FIELD_W-1:0];
    endfunction

endpackage

// File: rtl/core/dssm_ram.sv
module dssm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/dssm_ctrl.sv
module dssm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  dssm_pkg::dp_stat_t dp_stat,
    output dssm_pkg::dp_cmd_t  dp_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next     = state_reg;
        dp_cmd.load    = 1'b0;
        dp_cmd.exec    = 1'b0;
        dp_cmd.publish = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    dp_cmd.load = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                dp_cmd.exec = 1'b1;
                state_next  = S_FINISH;
            end
            S_FINISH:
            begin
                // hold until the output register is free
                if (dp_stat.out_free)
                begin
                    dp_cmd.publish = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

// File: rtl/core/dssm_datapath.sv
module dssm_datapath (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  dssm_pkg::dp_cmd_t                       dp_cmd,
    output dssm_pkg::dp_stat_t                      dp_stat,
    input  logic [dssm_pkg::CMD_W-1:0]              cmd,
    input  logic signed [dssm_pkg::WORD_W-1:0]      push_value,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic [dssm_pkg::STAT_W-1:0]             status,
    output logic signed [dssm_pkg::WORD_W-1:0]      pop_value,
    output logic [dssm_pkg::COUNT_FIELD_W-1:0]      left_count,
    output logic [dssm_pkg::COUNT_FIELD_W-1:0]      right_count
);

    localparam logic [dssm_pkg::CNT_W:0]   DEPTH_SUM = (dssm_pkg::CNT_W + 1)'(dssm_pkg::DEPTH);
    localparam logic [dssm_pkg::CNT_W-1:0] DEPTH_CNT = dssm_pkg::CNT_W'(dssm_pkg::DEPTH);

    // Captured transfer
    logic [dssm_pkg::CMD_W-1:0]  cmd_reg;
    logic [dssm_pkg::WORD_W-1:0] value_reg;

    // Stack pointers
    logic [dssm_pkg::CNT_W-1:0]  left_reg;
    logic [dssm_pkg::CNT_W-1:0]  left_next;
    logic [dssm_pkg::CNT_W-1:0]  right_reg;
    logic [dssm_pkg::CNT_W-1:0]  right_next;

    // Operation outcome
    logic [dssm_pkg::STAT_W-1:0] op_status_reg;
    logic [dssm_pkg::STAT_W-1:0] op_status_next;
    logic                        pop_ok_reg;
    logic                        pop_ok_next;

    // Output register
    logic                        out_valid_reg;
    logic [dssm_pkg::STAT_W-1:0] status_reg;
    logic [dssm_pkg::WORD_W-1:0] pop_value_reg;
    logic [dssm_pkg::COUNT_FIELD_W-1:0] left_count_reg;
    logic [dssm_pkg::COUNT_FIELD_W-1:0] right_count_reg;

    // Memory port
    logic                         mem_we;
    logic                         mem_re;
    logic [dssm_pkg::ADDR_W-1:0]  mem_waddr;
    logic [dssm_pkg::ADDR_W-1:0]  mem_raddr;
    logic [dssm_pkg::WORD_W-1:0]  mem_rdata;

    logic                         full;
    logic [dssm_pkg::CNT_W:0]     used;
    logic [dssm_pkg::CNT_W-1:0]   left_dec;
    logic [dssm_pkg::CNT_W-1:0]   right_inc;
    logic [dssm_pkg::CNT_W-1:0]   right_top;
    logic [dssm_pkg::CNT_W-1:0]   right_push_addr;

    assign used      = {1'b0, left_reg} + {1'b0, right_reg};
    assign full      = (used >= DEPTH_SUM);
    assign left_dec  = left_reg - 1'b1;
    assign right_inc = right_reg + 1'b1;
    assign right_top       = DEPTH_CNT - right_reg;
    assign right_push_addr = DEPTH_CNT - right_inc;

    always_comb
    begin
        left_next      = left_reg;
        right_next     = right_reg;
        op_status_next = dssm_pkg::ST_DONE;
        pop_ok_next    = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = left_reg[dssm_pkg::ADDR_W-1:0];
        mem_raddr      = left_dec[dssm_pkg::ADDR_W-1:0];
        case (cmd_reg)
            dssm_pkg::CMD_PUSH_LEFT:
            begin
                mem_waddr = left_reg[dssm_pkg::ADDR_W-1:0];
                if (full)
                begin
                    op_status_next = dssm_pkg::ST_FULL;
                end
                else
                begin
                    mem_we    = dp_cmd.exec;
                    left_next = left_reg + 1'b1;
                end
            end
            dssm_pkg::CMD_PUSH_RIGHT:
            begin
                mem_waddr = right_push_addr[dssm_pkg::ADDR_W-1:0];
                if (full)
                begin
                    op_status_next = dssm_pkg::ST_FULL;
                end
                else
                begin
                    mem_we     = dp_cmd.exec;
                    right_next = right_inc;
                end
            end
            dssm_pkg::CMD_POP_LEFT:
            begin
                mem_raddr = left_dec[dssm_pkg::ADDR_W-1:0];
                if (left_reg == '0)
                begin
                    op_status_next = dssm_pkg::ST_EMPTY;
                end
                else
                begin
                    mem_re      = dp_cmd.exec;
                    pop_ok_next = 1'b1;
                    left_next   = left_dec;
                end
            end
            dssm_pkg::CMD_POP_RIGHT:
            begin
                mem_raddr = right_top[dssm_pkg::ADDR_W-1:0];
                if (right_reg == '0)
                begin
                    op_status_next = dssm_pkg::ST_EMPTY;
                end
                else
                begin
                    mem_re      = dp_cmd.exec;
                    pop_ok_next = 1'b1;
                    right_next  = right_reg - 1'b1;
                end
            end
            default:
            begin
                op_status_next = dssm_pkg::ST_DONE;
            end
        endcase
    end

    dssm_ram #(
        .WIDTH (dssm_pkg::WORD_W),
        .DEPTH (dssm_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (value_reg),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Payload capture
    always_ff @(posedge clk)
    begin
        if (dp_cmd.load)
        begin
            cmd_reg   <= cmd;
            value_reg <= push_value;
        end
        if (dp_cmd.exec)
        begin
            op_status_reg <= op_status_next;
            pop_ok_reg    <= pop_ok_next;
        end
        if (dp_cmd.publish)
        begin
            status_reg      <= op_status_reg;
            pop_value_reg   <= pop_ok_reg ? mem_rdata : '0;
            left_count_reg  <= dssm_pkg::count_field(left_reg);
            right_count_reg <= dssm_pkg::count_field(right_reg);
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            right_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (dp_cmd.exec)
            begin
                left_reg  <= left_next;
                right_reg <= right_next;
            end
            if (dp_cmd.publish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign dp_stat.out_free = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign pop_value   = pop_value_reg;
    assign left_count  = left_count_reg;
    assign right_count = right_count_reg;

endmodule

// File: rtl/core/dual_stack_shared_memory.sv
// Two stacks sharing one array of dssm_pkg::DEPTH 32-bit words: the left stack grows up from
// entry 0, the right stack grows down from the top entry. Each input transfer carries a
// command (push left, push right, pop left, pop right) and a word; each produces exactly one
// output transfer with a status (done, full push refused, pop from empty), the popped word
// (zero for pushes and failed pops) and both stack counts after the operation. A command
// passes through capture, one access of the shared array, then loading of the output
// register once the read data has come back and the output register is free; a new command
// is taken only after the previous one has loaded its result. The output register
// holds a finished result while the next command is already being captured.
module dual_stack_shared_memory (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [dssm_pkg::CMD_W-1:0]              cmd,
    input  logic signed [dssm_pkg::WORD_W-1:0]      push_value,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic [dssm_pkg::STAT_W-1:0]             status,
    output logic signed [dssm_pkg::WORD_W-1:0]      pop_value,
    output logic [dssm_pkg::COUNT_FIELD_W-1:0]      left_count,
    output logic [dssm_pkg::COUNT_FIELD_W-1:0]      right_count
);

    dssm_pkg::dp_cmd_t  dp_cmd;
    dssm_pkg::dp_stat_t dp_stat;

    // Sequencer: capture, execute, publish
    dssm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .dp_stat  (dp_stat),
        .dp_cmd   (dp_cmd)
    );

    // Pointers, shared array and output register
    dssm_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .dp_cmd      (dp_cmd),
        .dp_stat     (dp_stat),
        .cmd         (cmd),
        .push_value  (push_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .pop_value   (pop_value),
        .left_count  (left_count),
        .right_count (right_count)
    );

endmodule

// File: verif/dual_stack_shared_memory_tb.sv
module dual_stack_shared_memory_tb;

    // Cycles without any transfer on either channel before the run is abandoned
    localparam int IDLE_LIMIT   = 2000;
    // Cycles to watch for stray results once every expected one has arrived
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [dssm_pkg::STAT_W-1:0]        status;
        logic [dssm_pkg::WORD_W-1:0]        pop_value;
        logic [dssm_pkg::COUNT_FIELD_W-1:0] left_count;
        logic [dssm_pkg::COUNT_FIELD_W-1:0] right_count;
    } stack_result_t;

    logic                                  clk = 1'b0;
    logic                                  rst_n = 1'b0;
    logic                                  in_valid = 1'b0;
    logic                                  in_stall;
    logic [dssm_pkg::CMD_W-1:0]            cmd = dssm_pkg::CMD_PUSH_LEFT;
    logic signed [dssm_pkg::WORD_W-1:0]    push_value = '0;
    logic                                  out_valid;
    logic                                  out_stall = 1'b0;
    logic [dssm_pkg::STAT_W-1:0]           status;
    logic signed [dssm_pkg::WORD_W-1:0]    pop_value;
    logic [dssm_pkg::COUNT_FIELD_W-1:0]    left_count;
    logic [dssm_pkg::COUNT_FIELD_W-1:0]    right_count;

    // Shadow copy of the shared array and of both stack depths
    logic [dssm_pkg::WORD_W-1:0] shadow_words [dssm_pkg::DEPTH];
    int                shadow_left = 0;
    int                shadow_right = 0;

    // Results still owed by the block, oldest first
    stack_result_t     owed_results [$];
    int                failures = 0;
    int                burst_left = 1;

    // Transfers seen at the falling edge, committed at the next rising edge
    logic              cmd_taken = 1'b0;
    logic              result_taken = 1'b0;
    stack_result_t     seen_result;

    int                idle_cycles = 0;

    // Receiver behaviour
    int                stall_mode = 0;
    int                stall_left = 0;

    dual_stack_shared_memory uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .push_value  (push_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .pop_value   (pop_value),
        .left_count  (left_count),
        .right_count (right_count)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Work out the result of one command against the shadow state and
    // advance that state. Counts are reported modulo 2**COUNT_FIELD_W.
    function automatic stack_result_t predict_stack_op(
        input logic [dssm_pkg::CMD_W-1:0] op,
        input logic [dssm_pkg::WORD_W-1:0] word);
        stack_result_t r;
        logic          full;
        full        = (shadow_left + shadow_right) >= dssm_pkg::DEPTH;
        r.status    = dssm_pkg::ST_DONE;
        r.pop_value = '0;
        case (op)
            dssm_pkg::CMD_PUSH_LEFT:
            begin
                if (full)
                begin
                    r.status = dssm_pkg::ST_FULL;
                end
                else
                begin
                    shadow_words[shadow_left] = word;
                    shadow_left++;
                end
            end
            dssm_pkg::CMD_PUSH_RIGHT:
            begin
                if (full)
                begin
                    r.status = dssm_pkg::ST_FULL;
                end
                else
                begin
                    shadow_right++;
                    shadow_words[dssm_pkg::DEPTH - shadow_right] = word;
                end
            end
            dssm_pkg::CMD_POP_LEFT:
            begin
                if (shadow_left == 0)
                begin
                    r.status = dssm_pkg::ST_EMPTY;
                end
                else
                begin
                    shadow_left--;
                    r.pop_value = shadow_words[shadow_left];
                end
            end
            default:
            begin
                if (shadow_right == 0)
                begin
                    r.status = dssm_pkg::ST_EMPTY;
                end
                else
                begin
                    r.pop_value = shadow_words[dssm_pkg::DEPTH - shadow_right];
                    shadow_right--;
                end
            end
        endcase
        r.left_count  = shadow_left[dssm_pkg::COUNT_FIELD_W-1:0];
        r.right_count = shadow_right[dssm_pkg::COUNT_FIELD_W-1:0];
        return r;
    endfunction

    // Mostly random words, with the corners of the signed range mixed in
    function automatic logic [dssm_pkg::WORD_W-1:0] pick_word();
        logic [dssm_pkg::WORD_W-1:0] w;
        case ($urandom_range(0, 15))
            0:       w = 32'h7fff_ffff;
            1:       w = 32'h8000_0000;
            2:       w = 32'h0000_0000;
            3:       w = 32'hffff_ffff;
            4:       w = 32'h0000_0001;
            default: w = $urandom;
        endcase
        return w;
    endfunction

    // Offer one command and hold it until the block takes it. The expectation
    // is queued at the falling edge before the accepting rising edge, so it is
    // always in place before the checker can see the matching result. After
    // the transfer, either stay in the burst or drop valid for a random gap
    // with junk on the payload.
    task automatic send_command(input logic [dssm_pkg::CMD_W-1:0] op,
                                input logic [dssm_pkg::WORD_W-1:0] word);
        int gap;
        in_valid   <= 1'b1;
        cmd        <= op;
        push_value <= word;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        owed_results.push_back(predict_stack_op(op, word));
        @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            gap        = $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (gap)
            begin
                cmd        <= dssm_pkg::CMD_W'($urandom_range(0, 3));
                push_value <= $urandom;
                @(posedge clk);
            end
        end
    endtask

    // Drop valid and wait until every owed result has been delivered
    task automatic hold_until_drained();
        if (in_valid)
            in_valid <= 1'b0;
        do
            @(negedge clk);
        while (owed_results.size() != 0);
        @(posedge clk);
    endtask

    // Pops on both stacks straight after reset must report empty
    task automatic test_pop_empty();
        send_command(dssm_pkg::CMD_POP_LEFT, 32'h1234_5678);
        send_command(dssm_pkg::CMD_POP_RIGHT, 32'hdead_beef);
    endtask

    // Fill the array from both ends with corner values, try a push on each
    // side while full, then pop the top of each stack
    task automatic test_fill_and_refuse();
        logic [dssm_pkg::WORD_W-1:0] corners [8] = '{32'h7fff_ffff, 32'h8000_0000,
                                                     32'h0000_0000, 32'hffff_ffff,
                                                     32'h5555_5555, 32'haaaa_aaaa,
                                                     32'h0000_0001, 32'hfffe_0001};
        for (int i = 0; i < dssm_pkg::DEPTH; i++)
        begin
            if (i[0])
                send_command(dssm_pkg::CMD_PUSH_RIGHT, ~corners[(i / 2) % 8]);
            else
                send_command(dssm_pkg::CMD_PUSH_LEFT, corners[(i / 2) % 8]);
        end
        send_command(dssm_pkg::CMD_PUSH_LEFT, 32'hcafe_f00d);
        send_command(dssm_pkg::CMD_PUSH_RIGHT, 32'h0bad_f00d);
        send_command(dssm_pkg::CMD_POP_LEFT, '0);
        send_command(dssm_pkg::CMD_POP_RIGHT, '0);
    endtask

    // Random commands in segments that lean towards pushing, popping or
    // neither, so the array swings repeatedly between empty and full
    task automatic test_random_traffic(input int n_cmds);
        int                         seg_left;
        int                         push_pct;
        logic [dssm_pkg::CMD_W-1:0] op;
        seg_left = 0;
        push_pct = 50;
        for (int n = 0; n < n_cmds; n++)
        begin
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(10, 60);
                case ($urandom_range(0, 2))
                    0:       push_pct = 20;
                    1:       push_pct = 50;
                    default: push_pct = 85;
                endcase
            end
            seg_left--;
            if ($urandom_range(0, 99) < push_pct)
                op = $urandom_range(0, 1) ? dssm_pkg::CMD_PUSH_RIGHT : dssm_pkg::CMD_PUSH_LEFT;
            else
                op = $urandom_range(0, 1) ? dssm_pkg::CMD_POP_RIGHT : dssm_pkg::CMD_POP_LEFT;
            send_command(op, pick_word());
        end
    endtask

    // Let the block run completely dry in mid-traffic, then carry on
    task automatic test_pause_for_drain();
        send_command(dssm_pkg::CMD_PUSH_LEFT, pick_word());
        send_command(dssm_pkg::CMD_PUSH_RIGHT, pick_word());
        hold_until_drained();
        send_command(dssm_pkg::CMD_POP_LEFT, '0);
        send_command(dssm_pkg::CMD_POP_RIGHT, '0);
    endtask

    // Sample both handshakes at the falling edge, when every input and output
    // has settled; the transfer itself happens at the following rising edge.
    always @(negedge clk)
    begin
        cmd_taken               = rst_n && in_valid && !in_stall;
        result_taken            = rst_n && out_valid && !out_stall;
        seen_result.status      = status;
        seen_result.pop_value   = pop_value;
        seen_result.left_count  = left_count;
        seen_result.right_count = right_count;
    end

    // Compare each delivered result with the oldest owed one, field by field
    always @(posedge clk)
    begin
        stack_result_t want;
        if (result_taken)
        begin
            if (owed_results.size() == 0)
            begin
                $error("result with no command outstanding: status %0d pop_value %h",
                       seen_result.status, seen_result.pop_value);
                failures++;
            end
            else
            begin
                want = owed_results.pop_front();
                if (seen_result.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, seen_result.status);
                    failures++;
                end
                if (seen_result.pop_value !== want.pop_value)
                begin
                    $error("pop_value: expected %h, got %h",
                           want.pop_value, seen_result.pop_value);
                    failures++;
                end
                if (seen_result.left_count !== want.left_count)
                begin
                    $error("left_count: expected %0d, got %0d",
                           want.left_count, seen_result.left_count);
                    failures++;
                end
                if (seen_result.right_count !== want.right_count)
                begin
                    $error("right_count: expected %0d, got %0d",
                           want.right_count, seen_result.right_count);
                    failures++;
                end
            end
        end
    end

    // Receiver: alternate between free-flowing stretches, random stalls and
    // solid stalls
    always @(posedge clk)
    begin
        logic next_stall;
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = (stall_mode == 2) ? $urandom_range(1, 12) : $urandom_range(20, 60);
        end
        else
        begin
            stall_left--;
        end
        case (stall_mode)
            0:       next_stall = 1'b0;
            1:       next_stall = 1'($urandom_range(0, 1));
            default: next_stall = 1'b1;
        endcase
        out_stall <= next_stall;
    end

    // Abandon the run if neither channel moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || cmd_taken || result_taken)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_pop_empty();
        test_fill_and_refuse();
        test_random_traffic(700);
        test_pause_for_drain();
        test_random_traffic(800);

        // Wait for the last results, then watch a little longer for strays
        hold_until_drained();
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/dssm_pkg.sv
rtl/core/dssm_ram.sv
rtl/core/dssm_ctrl.sv
rtl/core/dssm_datapath.sv
rtl/core/dual_stack_shared_memory.sv
verif/dual_stack_shared_memory_tb.sv
